>>> hdl/mbcrtc_pkg.sv
package mbcrtc_pkg;

    typedef enum logic [2:0] {
        CMD_ROM_RD  = 3'd0,
        CMD_CTRL_WR = 3'd1,
        CMD_RAM_RD  = 3'd2,
        CMD_RAM_WR  = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_RTC  = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        CFG_ROM_BANK_MASK   = 2'd0,
        CFG_RAM_OFFSET_MASK = 2'd1,
        CFG_RAM_PRESENT     = 2'd2,
        CFG_CLOCK_PRESENT   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CTRL_RAM_ENABLE = 2'd0,
        CTRL_ROM_BANK   = 2'd1,
        CTRL_RAM_BANK   = 2'd2,
        CTRL_LATCH      = 2'd3
    } ctrl_region_t;

    localparam int unsigned RTC_BYTES = 5;
    localparam logic [2:0] RTC_SEC  = 3'd0;
    localparam logic [2:0] RTC_MIN  = 3'd1;
    localparam logic [2:0] RTC_HOUR = 3'd2;
    localparam logic [2:0] RTC_DLO  = 3'd3;
    localparam logic [2:0] RTC_DHI  = 3'd4;

    localparam int unsigned DH_MSB_BIT   = 0;
    localparam int unsigned DH_HALT_BIT  = 6;
    localparam logic [7:0]  DH_WR_MASK   = 8'hC1;
    localparam logic [7:0]  DH_KEEP_MASK = 8'hC0;
    localparam logic [7:0]  DH_CARRY     = 8'h80;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [7:0] OPEN_BUS      = 8'hFF;
    localparam logic [7:0] RAM_SEL_LAST  = 8'h03;
    localparam logic [7:0] RTC_SEL_FIRST = 8'h08;
    localparam logic [7:0] RTC_SEL_LAST  = 8'h0C;
    localparam logic [7:0] LATCH_ARM     = 8'h00;
    localparam logic [7:0] LATCH_FIRE    = 8'h01;

    typedef struct packed {
        logic       tick;
        logic       latch;
        logic       wr;
        logic [2:0] idx;
        logic [7:0] data;
    } rtc_ctrl_t;

    function automatic logic [2:0] div60(input logic [8:0] x);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= 4; k++) begin
            if (x >= 9'(k * 60)) begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] div24(input logic [8:0] x);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= 10; k++) begin
            if (x >= 9'(k * 24)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

endpackage

>>> hdl/mbcrtc_clock.sv
module mbcrtc_clock (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mbcrtc_pkg::rtc_ctrl_t  ctrl,
    input  logic [2:0]             rd_idx,
    output logic [7:0]             rd_byte
);

    logic [7:0] live_reg    [mbcrtc_pkg::RTC_BYTES];
    logic [7:0] live_next   [mbcrtc_pkg::RTC_BYTES];
    logic [7:0] latched_reg [mbcrtc_pkg::RTC_BYTES];
    logic [7:0] latched_next[mbcrtc_pkg::RTC_BYTES];

    logic [8:0] sec_sum;
    logic [2:0] sec_q;
    logic [8:0] min_sum;
    logic [2:0] min_q;
    logic [8:0] hour_sum;
    logic [3:0] hour_q;
    logic [9:0] day_sum;
    logic [7:0] wr_val;

    // one-second carry chain
    always_comb
    begin
        sec_sum  = {1'b0, live_reg[mbcrtc_pkg::RTC_SEC]} + 9'd1;
        sec_q    = mbcrtc_pkg::div60(sec_sum);
        min_sum  = {1'b0, live_reg[mbcrtc_pkg::RTC_MIN]} + {6'd0, sec_q};
        min_q    = mbcrtc_pkg::div60(min_sum);
        hour_sum = {1'b0, live_reg[mbcrtc_pkg::RTC_HOUR]} + {6'd0, min_q};
        hour_q   = mbcrtc_pkg::div24(hour_sum);
        day_sum  = {1'b0, live_reg[mbcrtc_pkg::RTC_DHI][mbcrtc_pkg::DH_MSB_BIT],
                    live_reg[mbcrtc_pkg::RTC_DLO]} + {6'd0, hour_q};
    end

    assign wr_val = (ctrl.idx == mbcrtc_pkg::RTC_DHI) ? (ctrl.data & mbcrtc_pkg::DH_WR_MASK)
                                                      : ctrl.data;

    always_comb
    begin
        live_next    = live_reg;
        latched_next = latched_reg;
        if (ctrl.tick && !live_reg[mbcrtc_pkg::RTC_DHI][mbcrtc_pkg::DH_HALT_BIT]) begin
            live_next[mbcrtc_pkg::RTC_SEC]  = 8'(sec_sum - 9'(sec_q * 60));
            live_next[mbcrtc_pkg::RTC_MIN]  = 8'(min_sum - 9'(min_q * 60));
            live_next[mbcrtc_pkg::RTC_HOUR] = 8'(hour_sum - 9'(hour_q * 24));
            live_next[mbcrtc_pkg::RTC_DLO]  = day_sum[7:0];
            live_next[mbcrtc_pkg::RTC_DHI]  =
                (live_reg[mbcrtc_pkg::RTC_DHI] & mbcrtc_pkg::DH_KEEP_MASK)
                | {7'd0, day_sum[8]}
                | (day_sum[9] ? mbcrtc_pkg::DH_CARRY : 8'h00);
        end
        if (ctrl.latch) begin
            latched_next = live_reg;
        end
        if (ctrl.wr) begin
            live_next[ctrl.idx]    = wr_val;
            latched_next[ctrl.idx] = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < mbcrtc_pkg::RTC_BYTES; i++) begin
                live_reg[i]    <= 8'h00;
                latched_reg[i] <= 8'h00;
            end
        end else begin
            live_reg    <= live_next;
            latched_reg <= latched_next;
        end
    end

    assign rd_byte = latched_reg[rd_idx];

endmodule

>>> hdl/bank_controller_with_rtc_top.sv
// Cartridge bank controller with real-time clock. Items enter on the in
// channel (cmd, bus_addr, data_in) and each yields one result on the out
// channel, in order. One item is taken every cycle while the out side is not
// stalling; an item is held in an input register, worked in one pass of
// short logic that also updates the bank, enable, latch and clock state,
// and its result lands in the output register. A stalled output holds the
// input register and then in_ready.
// The cfg port (index 0 rom bank mask, 1 ram offset mask, 2 ram present,
// 3 clock present) is always ready and must only be written while idle.
module bank_controller_with_rtc_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [14:0] bus_addr,
    input  logic [7:0]  data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  target,
    output logic [20:0] mapped_addr,
    output logic        mem_write,
    output logic [7:0]  write_byte,
    output logic [7:0]  read_data
);

    logic [6:0]  rom_bank_mask_reg;
    logic [14:0] ram_offset_mask_reg;
    logic        ram_present_reg;
    logic        clock_present_reg;

    logic [6:0]  rom_bank_sel_reg, rom_bank_sel_next;
    logic [7:0]  ram_bank_sel_reg, ram_bank_sel_next;
    logic        ram_enable_reg, ram_enable_next;
    logic [7:0]  latch_prev_reg, latch_prev_next;

    logic        s1_valid_reg;
    logic [2:0]  s1_cmd_reg;
    logic [14:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;

    logic        out_valid_reg;
    logic [1:0]  target_reg, target_next;
    logic [20:0] mapped_reg, mapped_next;
    logic        mem_write_reg, mem_write_next;
    logic [7:0]  write_byte_reg, write_byte_next;
    logic [7:0]  read_data_reg, read_data_next;

    logic                  advance;
    logic                  work;
    mbcrtc_pkg::rtc_ctrl_t rtc_ctrl;
    logic [2:0]            rtc_idx;
    logic [7:0]            rtc_byte;
    logic [7:0]            rtc_wr_val;
    logic [6:0]            bank_low;
    logic [15:0]           ram_sum;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign work      = s1_valid_reg && advance;

    assign rtc_idx    = 3'(ram_bank_sel_reg - mbcrtc_pkg::RTC_SEL_FIRST);
    assign rtc_wr_val = (rtc_idx == mbcrtc_pkg::RTC_DHI)
                        ? (s1_data_reg & mbcrtc_pkg::DH_WR_MASK) : s1_data_reg;
    assign bank_low   = s1_data_reg[6:0];
    assign ram_sum    = {1'b0, ram_bank_sel_reg[1:0], 13'd0} + {1'b0, s1_addr_reg};

    always_comb
    begin
        rom_bank_sel_next = rom_bank_sel_reg;
        ram_bank_sel_next = ram_bank_sel_reg;
        ram_enable_next   = ram_enable_reg;
        latch_prev_next   = latch_prev_reg;
        target_next       = mbcrtc_pkg::TGT_NONE;
        mapped_next       = 21'd0;
        mem_write_next    = 1'b0;
        write_byte_next   = 8'h00;
        read_data_next    = mbcrtc_pkg::OPEN_BUS;
        rtc_ctrl          = '0;
        rtc_ctrl.idx      = rtc_idx;
        rtc_ctrl.data     = s1_data_reg;

        unique case (mbcrtc_pkg::cmd_t'(s1_cmd_reg))
            mbcrtc_pkg::CMD_ROM_RD:
            begin
                target_next = mbcrtc_pkg::TGT_ROM;
                if (!s1_addr_reg[14]) begin
                    mapped_next = {6'd0, s1_addr_reg};
                end else begin
                    mapped_next = {rom_bank_sel_reg & rom_bank_mask_reg, s1_addr_reg[13:0]};
                end
            end
            mbcrtc_pkg::CMD_CTRL_WR:
            begin
                unique case (mbcrtc_pkg::ctrl_region_t'(s1_addr_reg[14:13]))
                    mbcrtc_pkg::CTRL_RAM_ENABLE:
                    begin
                        ram_enable_next = (s1_data_reg[3:0] == mbcrtc_pkg::RAM_EN_KEY);
                    end
                    mbcrtc_pkg::CTRL_ROM_BANK:
                    begin
                        rom_bank_sel_next = (bank_low == 7'd0) ? 7'd1 : bank_low;
                    end
                    mbcrtc_pkg::CTRL_RAM_BANK:
                    begin
                        ram_bank_sel_next = s1_data_reg;
                    end
                    mbcrtc_pkg::CTRL_LATCH:
                    begin
                        rtc_ctrl.latch  = work && (latch_prev_reg == mbcrtc_pkg::LATCH_ARM)
                                          && (s1_data_reg == mbcrtc_pkg::LATCH_FIRE);
                        latch_prev_next = s1_data_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            mbcrtc_pkg::CMD_RAM_RD,
            mbcrtc_pkg::CMD_RAM_WR:
            begin
                if (ram_enable_reg) begin
                    if (ram_bank_sel_reg <= mbcrtc_pkg::RAM_SEL_LAST) begin
                        if (ram_present_reg) begin
                            target_next = mbcrtc_pkg::TGT_RAM;
                            mapped_next = {6'd0, ram_sum[14:0] & ram_offset_mask_reg};
                            if (s1_cmd_reg == mbcrtc_pkg::CMD_RAM_WR) begin
                                mem_write_next  = 1'b1;
                                write_byte_next = s1_data_reg;
                            end
                        end
                    end else if (ram_bank_sel_reg >= mbcrtc_pkg::RTC_SEL_FIRST
                                 && ram_bank_sel_reg <= mbcrtc_pkg::RTC_SEL_LAST
                                 && clock_present_reg) begin
                        target_next = mbcrtc_pkg::TGT_RTC;
                        if (s1_cmd_reg == mbcrtc_pkg::CMD_RAM_WR) begin
                            rtc_ctrl.wr    = work;
                            read_data_next = rtc_wr_val;
                        end else begin
                            read_data_next = rtc_byte;
                        end
                    end
                end
            end
            mbcrtc_pkg::CMD_TICK:
            begin
                rtc_ctrl.tick = work;
            end
            default:
            begin
            end
        endcase
    end

    mbcrtc_clock u_clock (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rtc_ctrl),
        .rd_idx  (rtc_idx),
        .rd_byte (rtc_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rom_bank_mask_reg   <= 7'd1;
            ram_offset_mask_reg <= 15'd8191;
            ram_present_reg     <= 1'b0;
            clock_present_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (mbcrtc_pkg::cfg_idx_t'(cfg_index))
                mbcrtc_pkg::CFG_ROM_BANK_MASK:   rom_bank_mask_reg   <= cfg_data[6:0];
                mbcrtc_pkg::CFG_RAM_OFFSET_MASK: ram_offset_mask_reg <= cfg_data;
                mbcrtc_pkg::CFG_RAM_PRESENT:     ram_present_reg     <= cfg_data[0];
                mbcrtc_pkg::CFG_CLOCK_PRESENT:   clock_present_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rom_bank_sel_reg <= 7'd1;
            ram_bank_sel_reg <= 8'h00;
            ram_enable_reg   <= 1'b0;
            latch_prev_reg   <= 8'hFF;
        end else if (work) begin
            rom_bank_sel_reg <= rom_bank_sel_next;
            ram_bank_sel_reg <= ram_bank_sel_next;
            ram_enable_reg   <= ram_enable_next;
            latch_prev_reg   <= latch_prev_next;
        end
    end

    // hold the input item until the result register frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= bus_addr;
            s1_data_reg <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work) begin
            target_reg     <= target_next;
            mapped_reg     <= mapped_next;
            mem_write_reg  <= mem_write_next;
            write_byte_reg <= write_byte_next;
            read_data_reg  <= read_data_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = target_reg;
    assign mapped_addr = mapped_reg;
    assign mem_write   = mem_write_reg;
    assign write_byte  = write_byte_reg;
    assign read_data   = read_data_reg;

endmodule

>>> hdl/mbcrtc_checker.sv
module mbcrtc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  target,
    input logic [20:0] mapped_addr,
    input logic        mem_write,
    input logic [7:0]  write_byte,
    input logic [7:0]  read_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mapped_addr)
        && $stable(mem_write) && $stable(write_byte) && $stable(read_data))
        else $error("result changed while stalled");

    a_write_is_ram: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_write |-> target == mbcrtc_pkg::TGT_RAM)
        else $error("external write without RAM target");

    a_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == mbcrtc_pkg::TGT_NONE |->
        read_data == mbcrtc_pkg::OPEN_BUS && mapped_addr == 21'd0 && !mem_write
        && write_byte == 8'h00)
        else $error("open bus result not idle");

    a_rtc_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == mbcrtc_pkg::TGT_RTC |-> mapped_addr == 21'd0 && !mem_write)
        else $error("clock result drives memory");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind bank_controller_with_rtc_top mbcrtc_checker u_mbcrtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .target      (target),
    .mapped_addr (mapped_addr),
    .mem_write   (mem_write),
    .write_byte  (write_byte),
    .read_data   (read_data)
);

>>> test/tb_top.sv
module tb_top;

    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
    localparam logic [14:0] ROM_BANKED_BASE = 15'h4000;
    localparam int unsigned RAM_BANK_SPAN   = 'h2000;
    localparam int unsigned DAY_LAST        = 'h1FF;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned PHASE_ITEMS     = 200;
    localparam longint      RUN_LIMIT       = 2_000_000;

    typedef struct packed {
        mbcrtc_pkg::target_t tgt;
        logic [20:0]         addr;
        logic                wr;
        logic [7:0]          wbyte;
        logic [7:0]          rdata;
    } bus_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [14:0] bus_addr;
    logic [7:0]  data_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  target;
    logic [20:0] mapped_addr;
    logic        mem_write;
    logic [7:0]  write_byte;
    logic [7:0]  read_data;

    logic [6:0]  rom_mask_q;
    logic [14:0] ram_mask_q;
    logic        ram_fitted;
    logic        clock_fitted;
    logic [6:0]  rom_page;
    logic [7:0]  ram_select;
    logic        ram_on;
    logic [7:0]  latch_last;
    logic [7:0]  live_clk [mbcrtc_pkg::RTC_BYTES];
    logic [7:0]  held_clk [mbcrtc_pkg::RTC_BYTES];

    bus_result_t queued_mappings [$];
    bus_result_t want;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned tick_count;
    int unsigned setting_count;
    int unsigned fail_count;
    bit          gaps_on;
    bit          stalls_on;

    bank_controller_with_rtc_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .bus_addr    (bus_addr),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .target      (target),
        .mapped_addr (mapped_addr),
        .mem_write   (mem_write),
        .write_byte  (write_byte),
        .read_data   (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic map_bus_access(input logic [2:0] c, input logic [14:0] a,
                                  input logic [7:0] d);
        bus_result_t r;
        logic [2:0]  reg_sel;
        logic [7:0]  v;
        logic [7:0]  dh;
        int unsigned s;
        int unsigned m;
        int unsigned h;
        int unsigned day_count;
        r = '{tgt: mbcrtc_pkg::TGT_NONE, addr: '0, wr: 1'b0, wbyte: '0,
              rdata: mbcrtc_pkg::OPEN_BUS};
        case (c)
            mbcrtc_pkg::CMD_ROM_RD:
            begin
                r.tgt = mbcrtc_pkg::TGT_ROM;
                if (a < ROM_BANKED_BASE)
                    r.addr = 21'(a);
                else
                    r.addr = {rom_page & rom_mask_q, a[13:0]};
            end
            mbcrtc_pkg::CMD_CTRL_WR:
            begin
                case (mbcrtc_pkg::ctrl_region_t'(a[14:13]))
                    mbcrtc_pkg::CTRL_RAM_ENABLE: ram_on = (d[3:0] == mbcrtc_pkg::RAM_EN_KEY);
                    mbcrtc_pkg::CTRL_ROM_BANK:   rom_page = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
                    mbcrtc_pkg::CTRL_RAM_BANK:   ram_select = d;
                    mbcrtc_pkg::CTRL_LATCH:
                    begin
                        if (latch_last == mbcrtc_pkg::LATCH_ARM && d == mbcrtc_pkg::LATCH_FIRE)
                            held_clk = live_clk;
                        latch_last = d;
                    end
                endcase
            end
            mbcrtc_pkg::CMD_RAM_RD, mbcrtc_pkg::CMD_RAM_WR:
            begin
                if (ram_on) begin
                    if (ram_select <= mbcrtc_pkg::RAM_SEL_LAST) begin
                        if (ram_fitted) begin
                            r.tgt = mbcrtc_pkg::TGT_RAM;
                            r.addr = 21'((ram_select * RAM_BANK_SPAN + a) & ram_mask_q);
                            if (c == mbcrtc_pkg::CMD_RAM_WR) begin
                                r.wr = 1'b1;
                                r.wbyte = d;
                            end
                        end
                    end else if (ram_select >= mbcrtc_pkg::RTC_SEL_FIRST
                                 && ram_select <= mbcrtc_pkg::RTC_SEL_LAST
                                 && clock_fitted) begin
                        reg_sel = 3'(ram_select - mbcrtc_pkg::RTC_SEL_FIRST);
                        r.tgt = mbcrtc_pkg::TGT_RTC;
                        if (c == mbcrtc_pkg::CMD_RAM_WR) begin
                            v = (reg_sel == mbcrtc_pkg::RTC_DHI)
                                ? (d & mbcrtc_pkg::DH_WR_MASK) : d;
                            live_clk[reg_sel] = v;
                            held_clk[reg_sel] = v;
                        end
                        r.rdata = held_clk[reg_sel];
                    end
                end
            end
            mbcrtc_pkg::CMD_TICK:
            begin
                tick_count++;
                // advance one second with carries by division, unless halted
                if (!live_clk[mbcrtc_pkg::RTC_DHI][mbcrtc_pkg::DH_HALT_BIT]) begin
                    s = live_clk[mbcrtc_pkg::RTC_SEC] + 1;
                    live_clk[mbcrtc_pkg::RTC_SEC] = 8'(s % 60);
                    m = live_clk[mbcrtc_pkg::RTC_MIN] + s / 60;
                    live_clk[mbcrtc_pkg::RTC_MIN] = 8'(m % 60);
                    h = live_clk[mbcrtc_pkg::RTC_HOUR] + m / 60;
                    live_clk[mbcrtc_pkg::RTC_HOUR] = 8'(h % 24);
                    day_count = {live_clk[mbcrtc_pkg::RTC_DHI][mbcrtc_pkg::DH_MSB_BIT],
                                 live_clk[mbcrtc_pkg::RTC_DLO]} + h / 24;
                    live_clk[mbcrtc_pkg::RTC_DLO] = day_count[7:0];
                    dh = live_clk[mbcrtc_pkg::RTC_DHI] & mbcrtc_pkg::DH_KEEP_MASK;
                    dh[mbcrtc_pkg::DH_MSB_BIT] = day_count[8];
                    if (day_count > DAY_LAST)
                        dh = dh | mbcrtc_pkg::DH_CARRY;
                    live_clk[mbcrtc_pkg::RTC_DHI] = dh;
                end
            end
            default:
            begin
            end
        endcase
        queued_mappings.push_back(r);
    endtask

    task automatic send_access(input logic [2:0] c, input logic [14:0] a, input logic [7:0] d);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        bus_addr <= a;
        data_in  <= d;
        do @(posedge clk); while (!in_ready);
        map_bus_access(c, a, d);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (queued_mappings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_settings(input logic [14:0] rom_mask_w, input logic [14:0] ram_mask_w,
                                    input logic [14:0] ram_w, input logic [14:0] clock_w);
        logic [14:0]          vals [4];
        mbcrtc_pkg::cfg_idx_t idx;
        vals = '{rom_mask_w, ram_mask_w, ram_w, clock_w};
        for (int i = 0; i < 4; i++) begin
            idx = mbcrtc_pkg::cfg_idx_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                mbcrtc_pkg::CFG_ROM_BANK_MASK:   rom_mask_q = vals[i][6:0];
                mbcrtc_pkg::CFG_RAM_OFFSET_MASK: ram_mask_q = vals[i];
                mbcrtc_pkg::CFG_RAM_PRESENT:     ram_fitted = vals[i][0];
                mbcrtc_pkg::CFG_CLOCK_PRESENT:   clock_fitted = vals[i][0];
            endcase
        end
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic send_random_access();
        int unsigned roll;
        int unsigned sel_roll;
        logic [2:0]  c;
        logic [14:0] a;
        logic [7:0]  d;
        roll = $urandom_range(0, 99);
        a = 15'($urandom);
        d = 8'($urandom);
        if (roll < 18) begin
            c = mbcrtc_pkg::CMD_ROM_RD;
        end else if (roll < 45) begin
            c = mbcrtc_pkg::CMD_CTRL_WR;
            case (mbcrtc_pkg::ctrl_region_t'(a[14:13]))
                mbcrtc_pkg::CTRL_RAM_ENABLE:
                begin
                    if ($urandom_range(0, 3) != 0)
                        d[3:0] = mbcrtc_pkg::RAM_EN_KEY;
                end
                mbcrtc_pkg::CTRL_RAM_BANK:
                begin
                    sel_roll = $urandom_range(0, 9);
                    if (sel_roll < 4)
                        d = 8'($urandom_range(0, mbcrtc_pkg::RAM_SEL_LAST));
                    else if (sel_roll < 8)
                        d = 8'($urandom_range(mbcrtc_pkg::RTC_SEL_FIRST,
                                              mbcrtc_pkg::RTC_SEL_LAST));
                end
                mbcrtc_pkg::CTRL_LATCH:
                begin
                    if ($urandom_range(0, 4) != 0)
                        d = (latch_last == mbcrtc_pkg::LATCH_ARM)
                            ? mbcrtc_pkg::LATCH_FIRE : mbcrtc_pkg::LATCH_ARM;
                end
                default:
                begin
                end
            endcase
        end else if (roll < 70) begin
            c = mbcrtc_pkg::CMD_RAM_RD;
        end else if (roll < 87) begin
            c = mbcrtc_pkg::CMD_RAM_WR;
        end else if (roll < 98) begin
            c = mbcrtc_pkg::CMD_TICK;
        end else begin
            c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        send_access(c, a, d);
    endtask

    task automatic test_power_on_defaults();
        send_access(mbcrtc_pkg::CMD_ROM_RD, 15'h7FFF, 8'h00);
        send_access(mbcrtc_pkg::CMD_RAM_RD, 15'h0000, 8'h00);
        send_access(CMD_SPARE_LAST, 15'h7FFF, 8'hFF);
    endtask

    task automatic test_rom_banking();
        settle();
        program_settings(15'h007F, 15'h7FFF, 15'd1, 15'd1);
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h2000, 8'h00);
        send_access(mbcrtc_pkg::CMD_ROM_RD, 15'h7FFF, 8'h00);
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h3FFF, 8'hFF);
        send_access(mbcrtc_pkg::CMD_ROM_RD, 15'h7FFF, 8'hFF);
        send_access(mbcrtc_pkg::CMD_ROM_RD, 15'h0000, 8'h00);
    endtask

    task automatic test_ram_window();
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h1FFF, 8'hFA);
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h5FFF, mbcrtc_pkg::RAM_SEL_LAST);
        send_access(mbcrtc_pkg::CMD_RAM_WR, 15'h7FFF, 8'hFF);
        send_access(mbcrtc_pkg::CMD_RAM_RD, 15'h0000, 8'h00);
    endtask

    task automatic test_clock_registers();
        logic [7:0] preset [mbcrtc_pkg::RTC_BYTES];
        // out-of-range seconds ripple through to a day overflow; day high starts halted
        preset = '{8'd200, 8'd59, 8'd23, 8'hFF, 8'hFF};
        for (int i = 0; i < mbcrtc_pkg::RTC_BYTES; i++) begin
            send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h4000, 8'(mbcrtc_pkg::RTC_SEL_FIRST + i));
            send_access(mbcrtc_pkg::CMD_RAM_WR, 15'($urandom), preset[i]);
        end
        send_access(mbcrtc_pkg::CMD_TICK, 15'h0000, 8'h00);
        send_access(mbcrtc_pkg::CMD_RAM_WR, 15'h0000, 8'h01);
        send_access(mbcrtc_pkg::CMD_TICK, 15'h7FFF, 8'hFF);
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h6000, mbcrtc_pkg::LATCH_ARM);
        send_access(mbcrtc_pkg::CMD_CTRL_WR, 15'h7FFF, mbcrtc_pkg::LATCH_FIRE);
        send_access(mbcrtc_pkg::CMD_RAM_RD, 15'h0000, 8'h00);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0: program_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
                1: program_settings(15'h0000, 15'h0000, 15'd1, 15'd1);
                2: program_settings(15'($urandom), 15'($urandom), 15'd0, 15'd0);
                default: program_settings(15'($urandom), 15'($urandom), 15'($urandom),
                                          15'($urandom));
            endcase
            if (phase == RANDOM_PHASES - 1) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            repeat (PHASE_ITEMS) send_random_access();
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (queued_mappings.size() == 0) begin
                $error("target: expected nothing, got %0d", target);
                fail_count++;
            end else begin
                want = queued_mappings.pop_front();
                if (target !== want.tgt) begin
                    $error("target: expected %0d, got %0d", want.tgt, target);
                    fail_count++;
                end
                if (mapped_addr !== want.addr) begin
                    $error("mapped_addr: expected 0x%0h, got 0x%0h", want.addr, mapped_addr);
                    fail_count++;
                end
                if (mem_write !== want.wr) begin
                    $error("mem_write: expected %0d, got %0d", want.wr, mem_write);
                    fail_count++;
                end
                if (write_byte !== want.wbyte) begin
                    $error("write_byte: expected 0x%0h, got 0x%0h", want.wbyte, write_byte);
                    fail_count++;
                end
                if (read_data !== want.rdata) begin
                    $error("read_data: expected 0x%0h, got 0x%0h", want.rdata, read_data);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= mbcrtc_pkg::CFG_ROM_BANK_MASK;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= mbcrtc_pkg::CMD_ROM_RD;
        bus_addr  <= '0;
        data_in   <= '0;
        rom_mask_q   = 7'd1;
        ram_mask_q   = 15'h1FFF;
        ram_fitted   = 1'b0;
        clock_fitted = 1'b0;
        rom_page     = 7'd1;
        ram_select   = 8'd0;
        ram_on       = 1'b0;
        latch_last   = 8'hFF;
        for (int i = 0; i < mbcrtc_pkg::RTC_BYTES; i++) begin
            live_clk[i] = 8'd0;
            held_clk[i] = 8'd0;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_rom_banking();
        test_ram_window();
        test_clock_registers();
        test_random_settings();
        settle();

        $display("Sent %0d bus items (%0d clock ticks) across %0d register settings;",
                 items_sent, tick_count, setting_count);
        $display("checked %0d results, %0d field mismatches.", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
